// File: src/rqs_pkg.sv
// Package for the ready-queue scheduler: queue sizing, entry type,
// policy, action and status codes, sequencer states and the ring index helper.
// No dependencies.
`timescale 1ns / 1ps

package rqs_pkg;

  // Ready queue sizing.
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Selection rules.
  localparam logic [1:0] FCFS = 2'd0;
  localparam logic [1:0] SJF  = 2'd1;
  localparam logic [1:0] RR   = 2'd2;

  // Input actions.
  localparam logic [1:0] ACT_ADMIT    = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_SLICE    = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_ADMITTED   = 3'd0;
  localparam logic [2:0] STAT_FULL       = 3'd1;
  localparam logic [2:0] STAT_DISPATCHED = 3'd2;
  localparam logic [2:0] STAT_EMPTY      = 3'd3;
  localparam logic [2:0] STAT_REQUEUED   = 3'd4;
  localparam logic [2:0] STAT_FINISHED   = 3'd5;
  localparam logic [2:0] STAT_NONE_RUN   = 3'd6;

  // Register indexes on the configuration port.
  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  // One queued or running process.
  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] burst;
    logic [15:0] remaining;
  } entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_TAKE,
    S_SH_RD,
    S_SH_WR
  } state_t;

  // Physical slot of a queue offset; head + offset stays below twice the depth.
  function automatic logic [IDX_W-1:0] slot_f(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// File: src/ready_queue_cpu_scheduler_top.sv
// Ready-queue CPU scheduler top level: FCFS, SJF and round robin selection
// over a circular queue held in a single-port-write, registered-read memory.
// Depends on rqs_pkg.
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         s_tvalid / s_tready    tuser action, tdata pid, burst
//  m_axis    out        m_tvalid / m_tready    tuser status, tdata pid..ran_time
//  apb       in         psel, penable, pready  paddr, pwdata, prdata
//
// Admit, slice done and dispatch on an empty queue complete in the idle state.
// A dispatch reads the queue memory through one read port: a read and a compare
// state per entry scanned (only the head for FCFS and RR, every entry for SJF),
// one take state, then, behind an SJF pick that is not the head, a read and a
// write state per entry moved up and one closing read state.
// Reset is synchronous and clears the queue count, head, running process and
// output valid; the queue memory is not cleared. Input is taken only when idle
// with a free output.
`timescale 1ns / 1ps

module ready_queue_cpu_scheduler_top
  import rqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] action
  input  logic [31:0] s_tdata,   // [15:0] pid, [31:16] burst
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic [63:0] m_tdata,   // [15:0] out_pid, [31:16] out_burst,
                                 // [47:32] out_remaining, [63:48] ran_time
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [1:0]  policy;
  logic [15:0] quantum;

  // Queue and sequencer state.
  state_t           state, state_next;
  logic [CNT_W-1:0] queue_count, queue_count_next;
  logic [IDX_W-1:0] queue_head, queue_head_next;
  logic [CNT_W-1:0] scan_i, scan_i_next;
  logic [CNT_W-1:0] pick, pick_next;
  entry_t           best, best_next;
  entry_t           running_entry, running_entry_next;
  logic             running_valid, running_valid_next;

  // Output register.
  logic        m_tvalid_next;
  logic [2:0]  m_tuser_next;
  logic [63:0] m_tdata_next;

  // Memory port signals.
  entry_t           mem [QUEUE_DEPTH];
  entry_t           rdata;
  logic [IDX_W-1:0] raddr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // Input item fields.
  logic [1:0]  in_action;
  logic [15:0] in_pid;
  logic [15:0] in_burst;
  logic        in_fire;
  logic        out_free;
  entry_t      slice_entry;
  logic [15:0] slice_rem;

  assign in_action = s_tuser;
  assign in_pid    = s_tdata[15:0];
  assign in_burst  = s_tdata[31:16];
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign in_fire   = s_tvalid && s_tready;

  // Configuration port: writes decode on word address, reads return the value.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= FCFS;
      quantum <= 16'd100;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_POLICY:  policy  <= pwdata[1:0];
        REG_QUANTUM: quantum <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POLICY:  prdata = {30'd0, policy};
      REG_QUANTUM: prdata = {16'd0, quantum};
      default:     prdata = 32'd0;
    endcase
  end

  // Queue memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[raddr];
  end

  // Running process after a round robin slice.
  assign slice_rem = running_entry.remaining - quantum;
  always_comb begin
    slice_entry           = running_entry;
    slice_entry.remaining = slice_rem;
  end

  // State and payload registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      queue_count   <= '0;
      queue_head    <= '0;
      running_entry <= '0;
      running_valid <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      queue_count   <= queue_count_next;
      queue_head    <= queue_head_next;
      running_entry <= running_entry_next;
      running_valid <= running_valid_next;
      m_tvalid      <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_i  <= scan_i_next;
    pick    <= pick_next;
    best    <= best_next;
    m_tuser <= m_tuser_next;
    m_tdata <= m_tdata_next;
  end

  // Sequencer: next state, queue updates, memory port and result.
  always_comb begin
    state_next         = state;
    queue_count_next   = queue_count;
    queue_head_next    = queue_head;
    scan_i_next        = scan_i;
    pick_next          = pick;
    best_next          = best;
    running_entry_next = running_entry;
    running_valid_next = running_valid;
    m_tvalid_next      = m_tvalid && !m_tready;
    m_tuser_next       = m_tuser;
    m_tdata_next       = m_tdata;
    raddr              = slot_f(queue_head, scan_i);
    wr_en              = 1'b0;
    wr_addr            = slot_f(queue_head, queue_count);
    wr_data            = '0;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_ADMIT: begin
              m_tvalid_next = 1'b1;
              if (queue_count < CNT_W'(QUEUE_DEPTH)) begin
                wr_en            = 1'b1;
                wr_data          = '{pid: in_pid, burst: in_burst, remaining: in_burst};
                queue_count_next = queue_count + 1'b1;
                m_tuser_next     = STAT_ADMITTED;
                m_tdata_next     = {16'd0, in_burst, in_burst, in_pid};
              end else begin
                m_tuser_next = STAT_FULL;
                m_tdata_next = '0;
              end
            end
            ACT_DISPATCH: begin
              if (queue_count == '0) begin
                m_tvalid_next = 1'b1;
                m_tuser_next  = STAT_EMPTY;
                m_tdata_next  = '0;
              end else begin
                scan_i_next = '0;
                state_next  = S_SCAN_RD;
              end
            end
            ACT_SLICE: begin
              m_tvalid_next = 1'b1;
              if (!running_valid) begin
                m_tuser_next = STAT_NONE_RUN;
                m_tdata_next = '0;
              end else if (policy == RR && running_entry.remaining > quantum) begin
                // Charge one quantum and put the process back at the tail if there is room.
                running_entry_next = slice_entry;
                m_tdata_next = {quantum, slice_rem, running_entry.burst,
                                running_entry.pid};
                if (queue_count < CNT_W'(QUEUE_DEPTH)) begin
                  wr_en              = 1'b1;
                  wr_data            = slice_entry;
                  queue_count_next   = queue_count + 1'b1;
                  running_valid_next = 1'b0;
                  m_tuser_next       = STAT_REQUEUED;
                end else begin
                  m_tuser_next = STAT_FULL;
                end
              end else begin
                // The process runs to completion.
                running_entry_next.remaining = '0;
                running_valid_next           = 1'b0;
                m_tuser_next                 = STAT_FINISHED;
                m_tdata_next = {running_entry.remaining, 16'd0,
                                running_entry.burst, running_entry.pid};
              end
            end
            default: ;
          endcase
        end
      end

      // Read one queued entry.
      S_SCAN_RD: begin
        raddr      = slot_f(queue_head, scan_i);
        state_next = S_SCAN_CMP;
      end

      // Keep the head, or under SJF the first entry with the strictly smallest burst.
      S_SCAN_CMP: begin
        if (scan_i == '0 || (policy == SJF && rdata.burst < best.burst)) begin
          best_next = rdata;
          pick_next = scan_i;
        end
        if (policy != SJF || scan_i + 1'b1 == queue_count) begin
          state_next = S_TAKE;
        end else begin
          scan_i_next = scan_i + 1'b1;
          state_next  = S_SCAN_RD;
        end
      end

      // Remove the pick: advance the head, or close the gap behind it.
      S_TAKE: begin
        if (pick == '0) begin
          queue_head_next    = slot_f(queue_head, CNT_W'(1));
          queue_count_next   = queue_count - 1'b1;
          running_entry_next = best;
          running_valid_next = 1'b1;
          m_tvalid_next      = 1'b1;
          m_tuser_next       = STAT_DISPATCHED;
          m_tdata_next       = {16'd0, best.remaining, best.burst, best.pid};
          state_next         = S_IDLE;
        end else begin
          scan_i_next = pick;
          state_next  = S_SH_RD;
        end
      end

      // Read the entry behind the gap, or finish when none is left.
      S_SH_RD: begin
        if (scan_i + 1'b1 < queue_count) begin
          raddr      = slot_f(queue_head, scan_i + 1'b1);
          state_next = S_SH_WR;
        end else begin
          queue_count_next   = queue_count - 1'b1;
          running_entry_next = best;
          running_valid_next = 1'b1;
          m_tvalid_next      = 1'b1;
          m_tuser_next       = STAT_DISPATCHED;
          m_tdata_next       = {16'd0, best.remaining, best.burst, best.pid};
          state_next         = S_IDLE;
        end
      end

      // Move that entry up by one place.
      S_SH_WR: begin
        wr_en       = 1'b1;
        wr_addr     = slot_f(queue_head, scan_i);
        wr_data     = rdata;
        scan_i_next = scan_i + 1'b1;
        state_next  = S_SH_RD;
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule
